### rtl/emv_pkg.sv
// Shared widths, codes and reset values of the multi-turn velocity estimator.
`default_nettype none
package emv_pkg;

  localparam int TURN_W     = 32;  // multi-turn count
  localparam int VEL_W      = 28;  // filtered velocity, Q8
  localparam int AVG_W      = 16;  // averaged angle, Q4
  localparam int STATUS_W   = 3;
  localparam int INTERVAL_W = 16;
  localparam int LIMIT_W    = 24;
  localparam int WEIGHT_W   = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int MS_W       = 10;  // holds the ms-per-second factor

  localparam logic [MS_W-1:0]       MS_PER_S      = MS_W'(1000);
  localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE    = WEIGHT_W'(256);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = INTERVAL_W'(500);
  localparam logic [LIMIT_W-1:0]    LIMIT_RST     = LIMIT_W'(325949);
  localparam logic [WEIGHT_W-1:0]   WEIGHT_RST    = WEIGHT_W'(77);
  localparam logic [VEL_W-1:0]      VEL_MAX       = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0]      VEL_MIN       = {1'b1, {(VEL_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_INTERVAL = 2'd0,
    CFG_VEL_LIMIT    = 2'd1,
    CFG_VEL_WEIGHT   = 2'd2
  } emv_cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED    = 3'd0,
    ST_UNAVAIL    = 3'd1,
    ST_FIRST      = 3'd2,
    ST_BAD_INTVL  = 3'd3,
    ST_OVER_LIMIT = 3'd4
  } emv_status_t;

endpackage
`default_nettype wire

### rtl/emv_if.sv
// Sample and result channel interfaces (valid/ready).
`default_nettype none
interface emv_in_if #(
  parameter int ANGLE_BITS = 12,
  parameter int TIME_BITS  = 32
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] angle_counts;
  logic [TIME_BITS-1:0]  time_ms;
  logic                  sensor_ok;

  modport source (output valid, angle_counts, time_ms, sensor_ok, input ready);
  modport sink   (input valid, angle_counts, time_ms, sensor_ok, output ready);
endinterface

interface emv_out_if;
  import emv_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [TURN_W-1:0]   turn_angle;
  logic signed [VEL_W-1:0]    velocity_q8;
  logic        [AVG_W-1:0]    smoothed_angle_q4;
  logic        [STATUS_W-1:0] status;

  modport source (output valid, turn_angle, velocity_q8, smoothed_angle_q4, status,
                  input ready);
  modport sink   (input valid, turn_angle, velocity_q8, smoothed_angle_q4, status,
                  output ready);
endinterface
`default_nettype wire

### rtl/emv_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module emv_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quot
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0] quot_r, quot_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    num_nxt  = num_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      quot_nxt = '0;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      num_nxt  = {num_r[NUM_W-2:0], 1'b0};
      quot_nxt = {quot_r[NUM_W-2:0], fits};
      rem_nxt  = fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      cnt_nxt  = cnt_r - CNT_W'(1);
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    num_r  <= num_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quot = quot_r;
endmodule
`default_nettype wire

### rtl/encoder_multiturn_velocity.sv
// Multi-turn unwrapper and filtered velocity estimator for an absolute angle sensor.
// Usage:
//   in_ch  : one beat per sensor sample (angle_counts, time_ms, sensor_ok).
//   out_ch : one beat per sample: turn_angle, velocity_q8, smoothed_angle_q4, status.
//   cfg_*  : register writes (0 max interval, 1 velocity limit, 2 filter weight),
//            issued only while the block is idle.
// Timing: a sample is taken in the idle state; in_ch.ready drops until its result
//   is loaded into the output register. Samples that skip the velocity path
//   (sensor not ok, first sample, bad interval) go straight to the done state; the
//   over-limit case passes through the limit and compare states; a full update also
//   runs the divide, filter and apply states, dominated by the bit-serial divider
//   that produces one quotient bit per cycle for the ANGLE_BITS + 18 bit dividend.
// The output register decouples the two sides: the next sample is accepted while a
//   result still waits; a stalled receiver only holds the block once a second
//   result is ready, and then it sits in the done state until out_ch.ready.
// Reset (synchronous, active low): registers back to defaults, state cleared,
//   channel empty.
`default_nettype none
module encoder_multiturn_velocity #(
  parameter int ANGLE_BITS = 12,
  parameter int TIME_BITS  = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  emv_in_if.sink                             in_ch,
  emv_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [emv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [emv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import emv_pkg::*;

  localparam int DW       = ANGLE_BITS + 2;        // unwrap arithmetic
  localparam int M1K_W    = ANGLE_BITS + MS_W;     // |delta| * 1000
  localparam int NUM_W    = M1K_W + 8;             // |delta| * 256000
  localparam int PROD_W   = LIMIT_W + INTERVAL_W;  // limit * elapsed
  localparam int QX_W     = (NUM_W > VEL_W + 1) ? NUM_W : VEL_W + 1;
  localparam int SUM_A_W  = ANGLE_BITS + 5;
  localparam int AVG_S_W  = (SUM_A_W > AVG_W + 1) ? SUM_A_W : AVG_W + 1;
  localparam int FP_W     = VEL_W + 11;            // weight * velocity difference
  localparam int FS_W     = FP_W + 1;

  localparam logic signed [DW-1:0] HALF_TURN = DW'(1) << (ANGLE_BITS - 1);
  localparam logic signed [DW-1:0] FULL_TURN = DW'(1) << ANGLE_BITS;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_LIMIT   = 7'b0000010,
    S_COMPARE = 7'b0000100,
    S_DIV     = 7'b0001000,
    S_FILT    = 7'b0010000,
    S_APPLY   = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  // configuration
  logic [INTERVAL_W-1:0] max_interval_r;
  logic [LIMIT_W-1:0]    vel_limit_r;
  logic [WEIGHT_W-1:0]   vel_weight_r;

  // tracking state
  logic                  seeded_r;
  logic [ANGLE_BITS-1:0] last_angle_r;
  logic [TIME_BITS-1:0]  last_time_r;
  logic [TURN_W-1:0]     turn_accum_r;
  logic [AVG_W-1:0]      angle_avg_r;
  logic [VEL_W-1:0]      vel_filt_r;

  // per-sample working registers
  state_t                state_r, state_nxt;
  emv_status_t           status_r;
  logic                  neg_r;
  logic [ANGLE_BITS-1:0] mag_r;
  logic [INTERVAL_W-1:0] elapsed_r;
  logic [M1K_W-1:0]      mag1k_r;
  logic [PROD_W-1:0]     lim_prod_r;
  logic signed [FP_W-1:0] fprod_r;

  // output register
  logic                  out_valid_r;
  logic [TURN_W-1:0]     out_turn_r;
  logic [VEL_W-1:0]      out_vel_r;
  logic [AVG_W-1:0]      out_avg_r;
  logic [STATUS_W-1:0]   out_status_r;

  logic                  accept;
  logic                  load_out;
  logic signed [DW-1:0]  d_raw, d_unw;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  bad_interval;
  logic [AVG_S_W-1:0]    avg_sum;
  logic                  div_start, div_done;
  logic [NUM_W-1:0]      quot;
  logic [QX_W-1:0]       quot_x;
  logic [VEL_W-1:0]      raw_vel;
  logic [WEIGHT_W-1:0]   weight_eff;
  logic signed [VEL_W:0] vel_diff;
  logic signed [FS_W-1:0] filt_sum;

  assign accept   = in_ch.valid && (state_r == S_IDLE);
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // unwrap at half a turn; exactly half a turn is kept
  always_comb begin
    d_raw = DW'(in_ch.angle_counts) - DW'(last_angle_r);
    if (d_raw > HALF_TURN)       d_unw = d_raw - FULL_TURN;
    else if (d_raw < -HALF_TURN) d_unw = d_raw + FULL_TURN;
    else                         d_unw = d_raw;
  end

  assign elapsed      = in_ch.time_ms - last_time_r;
  assign bad_interval = (elapsed == '0) || (elapsed > TIME_BITS'(max_interval_r));
  assign avg_sum      = (AVG_S_W'(in_ch.angle_counts) << 4) + AVG_S_W'(angle_avg_r);

  // quotient to signed velocity with 28-bit saturation
  assign quot_x = QX_W'(quot);
  always_comb begin
    if (neg_r) begin
      raw_vel = (quot_x >= (QX_W'(1) << (VEL_W - 1))) ? VEL_MIN : VEL_W'(-quot_x);
    end else begin
      raw_vel = (quot_x > QX_W'(VEL_MAX)) ? VEL_MAX : VEL_W'(quot_x);
    end
  end

  // low-pass: (256*old + w*(raw-old) + 128) >> 8, floor
  assign weight_eff = (vel_weight_r > WEIGHT_ONE) ? WEIGHT_ONE : vel_weight_r;
  assign vel_diff   = $signed({raw_vel[VEL_W-1], raw_vel})
                    - $signed({vel_filt_r[VEL_W-1], vel_filt_r});
  assign filt_sum   = $signed({{(FS_W-VEL_W-8){vel_filt_r[VEL_W-1]}}, vel_filt_r, 8'd0})
                    + $signed({fprod_r[FP_W-1], fprod_r})
                    + FS_W'(128);

  assign div_start = (state_r == S_COMPARE) && ({{(PROD_W-M1K_W){1'b0}}, mag1k_r}
                                                <= lim_prod_r);

  emv_div #(
    .NUM_W (NUM_W),
    .DEN_W (INTERVAL_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({mag1k_r, 8'd0}),
    .den   (elapsed_r),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_ch.sensor_ok || !seeded_r || bad_interval) state_nxt = S_DONE;
          else                                               state_nxt = S_LIMIT;
        end
      end
      S_LIMIT:   state_nxt = S_COMPARE;
      S_COMPARE: state_nxt = div_start ? S_DIV : S_DONE;
      S_DIV:     state_nxt = div_done ? S_FILT : S_DIV;
      S_FILT:    state_nxt = S_APPLY;
      S_APPLY:   state_nxt = S_DONE;
      S_DONE:    state_nxt = load_out ? S_IDLE : S_DONE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // control and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      max_interval_r <= INTERVAL_RST;
      vel_limit_r    <= LIMIT_RST;
      vel_weight_r   <= WEIGHT_RST;
      seeded_r       <= 1'b0;
      last_angle_r   <= '0;
      last_time_r    <= '0;
      turn_accum_r   <= '0;
      angle_avg_r    <= '0;
      vel_filt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_out)                       out_valid_r <= 1'b1;
      else if (out_ch.ready)              out_valid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_INTERVAL: max_interval_r <= cfg_data[INTERVAL_W-1:0];
          CFG_VEL_LIMIT:    vel_limit_r    <= cfg_data[LIMIT_W-1:0];
          CFG_VEL_WEIGHT:   vel_weight_r   <= cfg_data[WEIGHT_W-1:0];
          default: ;
        endcase
      end

      if (accept && in_ch.sensor_ok) begin
        last_angle_r <= in_ch.angle_counts;
        last_time_r  <= in_ch.time_ms;
        seeded_r     <= 1'b1;
        if (seeded_r) begin
          turn_accum_r <= turn_accum_r + {{(TURN_W-DW){d_unw[DW-1]}}, d_unw};
          angle_avg_r  <= avg_sum[AVG_W:1];
        end
      end

      if (state_r == S_APPLY) vel_filt_r <= filt_sum[VEL_W+7:8];
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r     <= d_unw[DW-1];
      mag_r     <= ANGLE_BITS'(d_unw[DW-1] ? -d_unw : d_unw);
      elapsed_r <= elapsed[INTERVAL_W-1:0];
      if (!in_ch.sensor_ok)  status_r <= ST_UNAVAIL;
      else if (!seeded_r)    status_r <= ST_FIRST;
      else if (bad_interval) status_r <= ST_BAD_INTVL;
      else                   status_r <= ST_UPDATED;
    end
    if (state_r == S_LIMIT) begin
      lim_prod_r <= PROD_W'(vel_limit_r) * PROD_W'(elapsed_r);
      mag1k_r    <= M1K_W'(mag_r) * M1K_W'(MS_PER_S);
    end
    if ((state_r == S_COMPARE) && !div_start) status_r <= ST_OVER_LIMIT;
    if (state_r == S_FILT) fprod_r <= $signed({1'b0, weight_eff}) * vel_diff;
    if (load_out) begin
      out_turn_r   <= turn_accum_r;
      out_vel_r    <= vel_filt_r;
      out_avg_r    <= angle_avg_r;
      out_status_r <= status_r;
    end
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.turn_angle        = $signed(out_turn_r);
  assign out_ch.velocity_q8       = $signed(out_vel_r);
  assign out_ch.smoothed_angle_q4 = out_avg_r;
  assign out_ch.status            = out_status_r;
endmodule
`default_nettype wire

### rtl/emv_checker.sv
// Port-level assertions for the multi-turn velocity estimator, bound to the top level.
`default_nettype none
module emv_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [emv_pkg::TURN_W-1:0]    turn_angle,
  input wire logic [emv_pkg::VEL_W-1:0]     velocity_q8,
  input wire logic [emv_pkg::STATUS_W-1:0]  status
);
  import emv_pkg::*;

  // result beat is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // one sample in flight: ready drops after every accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample accepted while busy");

  // seeding happens before any count or velocity update
  a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_FIRST) |-> (turn_angle == '0) && (velocity_q8 == '0))
    else $error("first-sample result carries nonzero state");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == ST_UPDATED) || (status == ST_UNAVAIL) ||
                  (status == ST_FIRST) || (status == ST_BAD_INTVL) ||
                  (status == ST_OVER_LIMIT))
    else $error("undefined status code");
endmodule

bind encoder_multiturn_velocity emv_checker u_emv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .turn_angle  (out_ch.turn_angle),
  .velocity_q8 (out_ch.velocity_q8),
  .status      (out_ch.status)
);
`default_nettype wire

### tb/tb_top.sv
// Self-checking bench for the multi-turn unwrapper and velocity estimator.
`default_nettype none
module tb_top;
  import emv_pkg::*;

  // ---------------------------------------------------------------------------
  // Bench constants
  // ---------------------------------------------------------------------------
  localparam int     TURN_COUNTS   = 4096;          // counts per revolution
  localparam int     HALF_TURN     = 2048;
  localparam longint VEL_TOP       = 134217727;     // 28-bit signed saturation
  localparam longint VEL_BOTTOM    = -134217728;
  localparam int     SETTLE_CYCLES = 64;            // longer than the longest update
  localparam int     STALL_LIMIT   = 2000;          // cycles with no beat at all
  localparam int     PRINT_CAP     = 100;

  // one result beat, as the block reports it
  typedef struct packed {
    logic [TURN_W-1:0] turn;
    logic [VEL_W-1:0]  vel;
    logic [AVG_W-1:0]  avg;
    emv_status_t       status;
  } motion_result_t;

  // directed stimulus row; want is only used when typed is set
  typedef struct packed {
    logic [11:0]    angle;
    logic [31:0]    stamp;
    logic           ok;
    bit             typed;
    motion_result_t want;
  } sample_row_t;

  // one random phase: register values plus handshake pacing
  typedef struct packed {
    logic [INTERVAL_W-1:0] interval;
    logic [LIMIT_W-1:0]    limit;
    logic [WEIGHT_W-1:0]   weight;
    int unsigned           items;
    int unsigned           gap_pct;
    int unsigned           stall_pct;
  } phase_t;

  localparam motion_result_t UNCHECKED = '{32'd0, 28'd0, 16'd0, ST_UPDATED};

  // Directed part, run with reset register values. Typed rows are the
  // ones trivially read off the spec; the rest go through the predictor.
  localparam int N_ROWS = 15;
  localparam sample_row_t DIRECTED [N_ROWS] = '{
    // sensor down before any seed: everything still at reset
    '{12'd4095, 32'hFFFF_FFFF, 1'b0, 1'b1, '{32'd0, 28'd0, 16'd0, ST_UNAVAIL}},
    // first good sample only seeds
    '{12'd0,    32'hFFFF_FFFF, 1'b1, 1'b1, '{32'd0, 28'd0, 16'd0, ST_FIRST}},
    // 0 -> 4095 unwraps to -1, tick wraps to give 1 ms; raw = -256000 Q8
    '{12'd4095, 32'h0000_0000, 1'b1, 1'b1,
      '{32'hFFFF_FFFF, -28'sd77000, 16'd32760, ST_UPDATED}},
    // delta of exactly minus half a turn kept, zero elapsed time
    '{12'd2047, 32'd0,         1'b1, 1'b0, UNCHECKED},
    // exactly plus half a turn kept, far over the speed limit
    '{12'd4095, 32'd1,         1'b1, 1'b0, UNCHECKED},
    // interval exactly at the maximum, wrap through zero
    '{12'd0,    32'd501,       1'b1, 1'b0, UNCHECKED},
    // one past half a turn folds back; interval one past the maximum
    '{12'd2049, 32'd1002,      1'b1, 1'b0, UNCHECKED},
    '{12'd0,    32'd1003,      1'b1, 1'b0, UNCHECKED},
    // sensor drop after seeding: state must hold
    '{12'h555,  32'hAAAA_AAAA, 1'b0, 1'b0, UNCHECKED},
    '{12'd100,  32'd1004,      1'b1, 1'b0, UNCHECKED},
    // 325 counts in 1 ms sits right under the limit, 326 just over
    '{12'd425,  32'd1005,      1'b1, 1'b0, UNCHECKED},
    '{12'd751,  32'd1006,      1'b1, 1'b0, UNCHECKED},
    // negative velocity, then standstill over the full interval
    '{12'd700,  32'd1106,      1'b1, 1'b0, UNCHECKED},
    '{12'd700,  32'd1606,      1'b1, 1'b0, UNCHECKED},
    '{12'd0,    32'd0,         1'b0, 1'b0, UNCHECKED}
  };

  // Random phases. Covers register extremes: interval 0 (always a bad
  // interval), limit 0 (only standstill passes), weight 0 and 256, and a
  // weight above 256 that must act as 256.
  localparam int N_PHASES = 7;
  localparam phase_t PHASES [N_PHASES] = '{
    '{16'd500,   24'd325949,   9'd77,  70, 0,  0},
    '{16'd65535, 24'd16777215, 9'd256, 80, 55, 0},
    '{16'd1,     24'd0,        9'd0,   40, 0,  55},
    '{16'd2000,  24'd1000000,  9'd511, 80, 16, 16},
    '{16'd0,     24'd325949,   9'd1,   25, 55, 0},
    '{16'd50,    24'd4096,     9'd128, 70, 0,  55},
    '{16'd500,   24'd16777215, 9'd200, 85, 16, 16}
  };

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  emv_in_if #(.ANGLE_BITS(12), .TIME_BITS(32)) sample_ch ();
  emv_out_if                                   result_ch ();

  encoder_multiturn_velocity #(.ANGLE_BITS(12), .TIME_BITS(32)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (sample_ch),
    .out_ch    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the estimator's registers
  // ---------------------------------------------------------------------------
  logic [INTERVAL_W-1:0] m_interval = INTERVAL_RST;
  logic [LIMIT_W-1:0]    m_limit    = LIMIT_RST;
  logic [WEIGHT_W-1:0]   m_weight   = WEIGHT_RST;

  logic                    m_seeded     = 1'b0;
  logic [11:0]             m_last_angle = '0;
  logic [31:0]             m_last_stamp = '0;
  logic [TURN_W-1:0]       m_turns      = '0;
  logic [TURN_W-1:0]       m_ref_count  = '0;  // count at the last velocity reference
  logic [AVG_W-1:0]        m_avg        = '0;
  logic signed [VEL_W-1:0] m_vel        = '0;

  motion_result_t pending_results[$];   // expected beats, oldest first
  int unsigned    mismatch_count = 0;
  int unsigned    results_seen   = 0;
  int unsigned    tx_gap_pct     = 0;
  int unsigned    rx_stall_pct   = 0;
  int unsigned    quiet_cycles   = 0;

  // random walk of the simulated sensor
  logic [11:0] g_angle;
  logic [31:0] g_stamp;

  // Advance the predictor by one accepted sample and return its result.
  function automatic motion_result_t estimate_motion(input logic [11:0] angle,
                                                     input logic [31:0] stamp,
                                                     input logic ok);
    motion_result_t r;
    int             delta;
    logic [31:0]    elapsed;
    logic [31:0]    span;
    longint         diff, mag, quo, raw, wt, acc;
    r = UNCHECKED;
    if (!ok) begin
      r.status = ST_UNAVAIL;
    end else if (!m_seeded) begin
      // seed only: count, average and filter keep their values
      m_last_angle = angle;
      m_last_stamp = stamp;
      m_ref_count  = m_turns;
      m_seeded     = 1'b1;
      r.status     = ST_FIRST;
    end else begin
      // shortest-way unwrap; exactly half a turn keeps its sign
      delta = int'(angle) - int'(m_last_angle);
      if (delta > HALF_TURN) delta -= TURN_COUNTS;
      else if (delta < -HALF_TURN) delta += TURN_COUNTS;
      m_turns      = m_turns + 32'(delta);
      m_last_angle = angle;
      m_avg        = 16'((32'(angle) * 16 + 32'(m_avg)) >> 1);

      elapsed      = stamp - m_last_stamp;  // mod 2^32
      m_last_stamp = stamp;
      span         = m_turns - m_ref_count;
      diff         = longint'(signed'(span));
      mag          = (diff < 0) ? -diff : diff;

      if (elapsed == 0 || elapsed > 32'(m_interval)) begin
        r.status = ST_BAD_INTVL;
      end else if (mag * 1000 > longint'(m_limit) * longint'(elapsed)) begin
        r.status = ST_OVER_LIMIT;
      end else begin
        quo = (mag * 256000) / longint'(elapsed);  // truncates toward zero
        raw = (diff < 0) ? -quo : quo;
        if (raw > VEL_TOP) raw = VEL_TOP;
        if (raw < VEL_BOTTOM) raw = VEL_BOTTOM;
        wt  = (m_weight > 9'd256) ? 256 : longint'(m_weight);
        acc = wt * raw + (256 - wt) * longint'(m_vel) + 128;
        m_vel    = VEL_W'(acc >>> 8);  // arithmetic shift = floor
        r.status = ST_UPDATED;
      end
      // every seeded good sample moves the reference on
      m_ref_count = m_turns;
    end
    r.turn = m_turns;
    r.vel  = m_vel;
    r.avg  = m_avg;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("[%0t] beat %0d: %s", $time, results_seen, what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One sample beat. Random idle cycles first (valid low), then hold valid
  // until ready. Valid is not lowered at the end, so back-to-back beats
  // never see two assignments in one step.
  task automatic send_sample(input logic [11:0] angle, input logic [31:0] stamp,
                             input logic ok, input bit typed, input motion_result_t want);
    motion_result_t predicted;
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid        <= 1'b1;
    sample_ch.angle_counts <= angle;
    sample_ch.time_ms      <= stamp;
    sample_ch.sensor_ok    <= ok;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    predicted = estimate_motion(angle, stamp, ok);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait for every outstanding result. Always waits on the clock
  // before checking, so valid cannot bounce within a step.
  task automatic hold_until_drained();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write all three registers back to back, then mirror them.
  task automatic apply_settings(input phase_t ph);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_INTERVAL;
    cfg_data  <= CFG_DATA_W'(ph.interval);
    @(posedge clk);
    cfg_index <= CFG_VEL_LIMIT;
    cfg_data  <= ph.limit;
    @(posedge clk);
    cfg_index <= CFG_VEL_WEIGHT;
    cfg_data  <= CFG_DATA_W'(ph.weight);
    @(posedge clk);
    cfg_we     <= 1'b0;
    m_interval = ph.interval;
    m_limit    = ph.limit;
    m_weight   = ph.weight;
  endtask

  // Mostly plausible motion within the current interval and speed limit,
  // with dropouts, interval faults, wild jumps and clock resyncs mixed in.
  task automatic next_random_sample(output logic [11:0] angle, output logic [31:0] stamp,
                                    output logic ok);
    int unsigned pick;
    int unsigned span_hi;
    logic [31:0] dt;
    longint      reach;
    int          delta;
    pick = $urandom_range(0, 99);
    ok   = 1'b1;
    if (pick < 8) begin
      // dropout: junk fields, walk untouched
      angle = 12'($urandom);
      stamp = $urandom;
      ok    = 1'b0;
    end else begin
      if (pick < 13) begin
        // zero or too-long interval
        dt = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'(m_interval) + $urandom_range(1, 3000);
        g_angle += 12'($urandom_range(0, 200) - 100);
        g_stamp += dt;
      end else if (pick < 19) begin
        // arbitrary jump, usually too fast
        g_angle = 12'($urandom);
        g_stamp += $urandom_range(1, 20);
      end else if (pick < 21) begin
        // clock resync, sometimes just below the wrap
        g_stamp = ($urandom_range(0, 1) == 0) ? $urandom
                                              : 32'hFFFF_FFFF - $urandom_range(0, 20);
        g_angle += 12'($urandom_range(0, 20) - 10);
      end else begin
        // plausible motion: short intervals mostly, full range sometimes
        if (m_interval == 0) begin
          dt = $urandom_range(1, 5);
        end else begin
          span_hi = ($urandom_range(0, 99) < 80 && m_interval > 20) ? 20 : m_interval;
          dt      = $urandom_range(1, span_hi);
        end
        reach = longint'(m_limit) * longint'(dt) / 1000;
        if (reach > HALF_TURN) reach = HALF_TURN;
        if ($urandom_range(0, 9) == 0)  // right at the limit, either direction
          delta = ($urandom_range(0, 1) == 0) ? int'(reach) : -int'(reach);
        else
          delta = int'($urandom_range(0, 2 * int'(reach))) - int'(reach);
        g_angle += 12'(delta);
        g_stamp += dt;
      end
      angle = g_angle;
      stamp = g_stamp;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each accepted beat, then pick the next ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    motion_result_t want;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (result_ch.turn_angle !== want.turn)
          report_mismatch($sformatf("turn_angle %h, want %h", result_ch.turn_angle, want.turn));
        if (result_ch.velocity_q8 !== want.vel)
          report_mismatch($sformatf("velocity_q8 %0d, want %0d",
                                    result_ch.velocity_q8, $signed(want.vel)));
        if (result_ch.smoothed_angle_q4 !== want.avg)
          report_mismatch($sformatf("smoothed_angle_q4 %0d, want %0d",
                                    result_ch.smoothed_angle_q4, want.avg));
        if (result_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", result_ch.status, want.status));
      end
      results_seen++;
    end
    result_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Watchdog: any beat or register write clears it
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("encoder_multiturn_velocity: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : run
    logic [11:0] angle;
    logic [31:0] stamp;
    logic        ok;

    rst_n                  <= 1'b0;
    cfg_we                 <= 1'b0;
    cfg_index              <= CFG_MAX_INTERVAL;
    cfg_data               <= '0;
    sample_ch.valid        <= 1'b0;
    sample_ch.angle_counts <= '0;
    sample_ch.time_ms      <= '0;
    sample_ch.sensor_ok    <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at reset settings, no idling
    for (int i = 0; i < N_ROWS; i++)
      send_sample(DIRECTED[i].angle, DIRECTED[i].stamp, DIRECTED[i].ok,
                  DIRECTED[i].typed, DIRECTED[i].want);

    // random phases; registers change only with the block drained
    for (int p = 0; p < N_PHASES; p++) begin
      hold_until_drained();
      repeat (4) @(posedge clk);
      apply_settings(PHASES[p]);
      tx_gap_pct   = PHASES[p].gap_pct;
      rx_stall_pct = PHASES[p].stall_pct;
      g_angle      = 12'($urandom);
      g_stamp      = $urandom;
      for (int n = 0; n < PHASES[p].items; n++) begin
        next_random_sample(angle, stamp, ok);
        send_sample(angle, stamp, ok, 1'b0, UNCHECKED);
        // occasional full drain mid-phase
        if ($urandom_range(0, 59) == 0) hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("encoder_multiturn_velocity: match");
    else
      $display("encoder_multiturn_velocity: mismatch");
    $finish;
  end

endmodule
`default_nettype wire

### encoder_multiturn_velocity.f
rtl/emv_pkg.sv
rtl/emv_if.sv
rtl/emv_div.sv
rtl/encoder_multiturn_velocity.sv
rtl/emv_checker.sv
tb/tb_top.sv
